### hw/rtl/lslv_pkg.sv
// Shared constants, types and codes of the LED strip level visualizer.
package lslv_pkg;

  // Strip geometry
  localparam int STRIP_LENGTH = 60;
  localparam int MID          = STRIP_LENGTH / 2;
  localparam int ADDR_W       = $clog2(STRIP_LENGTH);
  localparam int LEN_W        = $clog2(STRIP_LENGTH + 1);
  localparam int CMP_W        = LEN_W + 1;

  // Field widths
  localparam int AMP_W        = 16;
  localparam int POS_W        = 6;
  localparam int COLOR_W      = 24;
  localparam int BRIGHT_W     = 7;
  localparam int PSIZE_W      = 3;
  localparam int PALETTE_LEN  = 6;

  // Configuration port
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_BASE = 3'd2;

  localparam logic [PSIZE_W-1:0] PSIZE_RESET = 3'd6;
  localparam logic [PSIZE_W-1:0] PSIZE_MAX   = 3'd6;

  localparam logic [COLOR_W-1:0] BAR_COLOR = 24'h0000FF;

  typedef enum logic [1:0] {
    MODE_BAR     = 2'd0,
    MODE_GREY    = 2'd1,
    MODE_PALETTE = 2'd2,
    MODE_OFF     = 2'd3
  } mode_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic prep;
    logic scale;
    logic step;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic at_last;
  } dp_sts_t;

endpackage

### hw/rtl/lslv_amp_if.sv
// Input channel carrying one amplitude sample per transaction.
interface lslv_amp_if;
  logic                        valid;
  logic                        ready;
  logic [lslv_pkg::AMP_W-1:0]  amplitude;

  modport source (output valid, output amplitude, input ready);
  modport sink   (input valid, input amplitude, output ready);
endinterface

### hw/rtl/lslv_led_if.sv
// Output channel carrying one LED colour per transaction.
interface lslv_led_if;
  logic                          valid;
  logic                          ready;
  logic [lslv_pkg::POS_W-1:0]    led_position;
  logic [lslv_pkg::COLOR_W-1:0]  led_color;
  logic                          frame_last;

  modport source (output valid, output led_position, output led_color, output frame_last,
                  input ready);
  modport sink   (input valid, input led_position, input led_color, input frame_last,
                  output ready);
endinterface

### hw/rtl/lslv_ctrl.sv
// Sequencing state machine: accept, prepare, scale, then sweep the frame.
module lslv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lslv_pkg::dp_sts_t sts_i,
  output lslv_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PREP  = 4'b0010,
    ST_SCALE = 4'b0100,
    ST_SWEEP = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   step;

  assign in_ready_o = (state_q == ST_IDLE);
  // one LED per cycle while the output register can take it
  assign step       = (state_q == ST_SWEEP) && sts_i.out_free;

  always_comb begin
    cmd_o.capture = in_valid_i && in_ready_o;
    cmd_o.prep    = (state_q == ST_PREP);
    cmd_o.scale   = (state_q == ST_SCALE);
    cmd_o.step    = step;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_PREP;
      ST_PREP:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_SWEEP;
      ST_SWEEP: if (step && sts_i.at_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/lslv_datapath.sv
// Config registers, level arithmetic, frame memory and output register.
module lslv_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lslv_pkg::dp_cmd_t                 cmd_i,
  output lslv_pkg::dp_sts_t                 sts_o,
  input  logic [lslv_pkg::AMP_W-1:0]        amplitude_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [lslv_pkg::POS_W-1:0]        led_position_o,
  output logic [lslv_pkg::COLOR_W-1:0]      led_color_o,
  output logic                              frame_last_o,
  input  logic                              cfg_we_i,
  input  logic [lslv_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lslv_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int AW    = lslv_pkg::ADDR_W;
  localparam int CW    = lslv_pkg::COLOR_W;
  localparam int BW    = lslv_pkg::BRIGHT_W;
  localparam int PW    = lslv_pkg::PSIZE_W;
  localparam int LW    = lslv_pkg::LEN_W;
  localparam int KW    = lslv_pkg::CMP_W;
  localparam int AMPW  = lslv_pkg::AMP_W;
  localparam int LITW  = AMPW + LW;

  localparam logic [AW-1:0] LAST_IDX = AW'(lslv_pkg::STRIP_LENGTH - 1);
  localparam logic [KW-1:0] MID_K    = KW'(lslv_pkg::MID);
  localparam logic [AW:0]   LEN_A    = (AW + 1)'(lslv_pkg::STRIP_LENGTH);

  // floor(x / 255) for products of an 8-bit and a 7-bit value
  function automatic logic [7:0] div255(input logic [14:0] x);
    logic [15:0] s;
    s = 16'(x) + 16'(x >> 8) + 16'd1;
    return s[15:8];
  endfunction

  // ---------------- configuration registers
  lslv_pkg::mode_e mode_q;
  logic [PW-1:0]   psize_q;
  logic [CW-1:0]   pal_q [lslv_pkg::PALETTE_LEN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= lslv_pkg::MODE_BAR;
      psize_q <= lslv_pkg::PSIZE_RESET;
      for (int k = 0; k < lslv_pkg::PALETTE_LEN; k++) pal_q[k] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == lslv_pkg::CFG_DISPLAY_MODE) begin
        mode_q <= lslv_pkg::mode_e'(cfg_data_i[1:0]);
      end
      if (cfg_idx_i == lslv_pkg::CFG_PALETTE_SIZE) begin
        psize_q <= cfg_data_i[PW-1:0];
      end
      for (int k = 0; k < lslv_pkg::PALETTE_LEN; k++) begin
        if (cfg_idx_i == lslv_pkg::CFG_PALETTE_BASE + 3'(k)) pal_q[k] <= cfg_data_i[CW-1:0];
      end
    end
  end

  // ---------------- per-sample arithmetic
  logic [AMPW-1:0] dn_q;
  logic [BW-1:0]   bright_q;
  logic [LW-1:0]   half_q;
  logic [CW-1:0]   color_q;
  logic [CW-1:0]   word_q;
  logic [2:0]      ptr_q, ptr_d;

  logic [AMPW-1:0] dn_d;
  logic [23:0]     bright_prod;
  logic [LITW-1:0] lit_prod;
  logic [CW-1:0]   pal_sel;
  logic [PW-1:0]   psize_eff;
  logic [3:0]      ptr_inc;

  // |amplitude - midpoint|
  assign dn_d = amplitude_i[AMPW-1] ? {1'b0, amplitude_i[AMPW-2:0]}
                                    : (16'h8000 - amplitude_i);

  assign bright_prod = {dn_q, 8'd0} - 24'(dn_q);
  assign lit_prod    = LITW'(dn_q) * LITW'(lslv_pkg::STRIP_LENGTH);

  always_comb begin
    unique case (ptr_q)
      3'd0:    pal_sel = pal_q[0];
      3'd1:    pal_sel = pal_q[1];
      3'd2:    pal_sel = pal_q[2];
      3'd3:    pal_sel = pal_q[3];
      3'd4:    pal_sel = pal_q[4];
      3'd5:    pal_sel = pal_q[5];
      default: pal_sel = '0;
    endcase
  end

  // palette size clamped to 1..6, pointer wraps at the size
  always_comb begin
    psize_eff = psize_q;
    if (psize_q == '0) psize_eff = PW'(1);
    if (psize_q > lslv_pkg::PSIZE_MAX) psize_eff = lslv_pkg::PSIZE_MAX;
    ptr_inc = 4'(ptr_q) + 4'd1;
    ptr_d   = (ptr_inc >= 4'(psize_eff)) ? 3'd0 : ptr_inc[2:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.prep && (mode_q == lslv_pkg::MODE_PALETTE)) begin
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) dn_q <= dn_d;
    if (cmd_i.prep) begin
      bright_q <= bright_prod[16 +: BW];
      half_q   <= lit_prod[15 +: LW];
      color_q  <= pal_sel;
    end
    // scaled colour, reordered to g, b, r
    if (cmd_i.scale) begin
      word_q <= {div255(15'(color_q[15:8]) * 15'(bright_q)),
                 div255(15'(color_q[7:0]) * 15'(bright_q)),
                 div255(15'(color_q[23:16]) * 15'(bright_q))};
    end
  end

  // ---------------- frame memory and sweep
  logic [CW-1:0] frame_mem [lslv_pkg::STRIP_LENGTH];
  logic [CW-1:0] rd_data_q;
  logic [CW-1:0] prv_q, cur_q;
  logic [AW-1:0] idx_q;
  logic          seeded_q;
  logic          out_valid_q;
  logic [AW:0]   ahead;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] new_color;
  logic [KW-1:0] idx_k, half_k;
  logic          bar_on;

  assign ahead = {1'b0, idx_q} + (AW + 1)'(2);

  // prime with entries 0 and 1, then read two ahead of the write
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    priority if (cmd_i.prep) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd_i.scale) begin
      rd_en   = 1'b1;
      rd_addr = AW'(1);
    end else if (cmd_i.step) begin
      rd_en   = (ahead < LEN_A);
      rd_addr = ahead[AW-1:0];
    end else begin
      rd_en   = 1'b0;
    end
  end

  assign idx_k  = KW'(idx_q);
  assign half_k = KW'(half_q);
  assign bar_on = (idx_k >= MID_K) ? (idx_k < MID_K + half_k) : (idx_k + half_k >= MID_K);

  // new colour of LED idx from the level, the scaled colour or its old neighbours
  always_comb begin
    unique case (mode_q)
      lslv_pkg::MODE_BAR:  new_color = bar_on ? lslv_pkg::BAR_COLOR : '0;
      lslv_pkg::MODE_GREY: begin
        new_color = (idx_q == '0) ? {1'b0, bright_q, 1'b0, bright_q, 1'b0, bright_q} : prv_q;
      end
      lslv_pkg::MODE_PALETTE: begin
        if (idx_k > MID_K)              new_color = prv_q;
        else if (idx_k + KW'(1) < MID_K) new_color = rd_data_q;
        else                             new_color = word_q;
      end
      default: new_color = '0;
    endcase
  end

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) frame_mem[idx_q] <= new_color;
    if (rd_en) rd_data_q <= seeded_q ? frame_mem[rd_addr] : '0;
  end

  // frame reads as zero until the first full sweep has written it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (cmd_i.step && (idx_q == LAST_IDX)) seeded_q <= 1'b1;
      if (cmd_i.step) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.capture) idx_q <= '0;
      else if (cmd_i.step) idx_q <= idx_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) cur_q <= rd_data_q;
    if (cmd_i.step) begin
      prv_q          <= cur_q;
      cur_q          <= rd_data_q;
      led_position_o <= lslv_pkg::POS_W'(idx_q);
      led_color_o    <= new_color;
      frame_last_o   <= (idx_q == LAST_IDX);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.at_last  = (idx_q == LAST_IDX);

endmodule

### hw/rtl/led_strip_level_visualizer_unit.sv
// Top level of the LED strip level visualizer.
//
//  channel   dir  handshake        payload
//  amp_in    in   valid / ready    amplitude[15:0]
//  led_out   out  valid / ready    led_position[5:0], led_color[23:0], frame_last
//  cfg       in   cfg_we_i         cfg_idx_i[2:0], cfg_data_i[23:0]
//
// A sample is accepted in the idle state, the level and scaled colour are formed in the
// prep and scale states, then the sweep emits one LED per cycle while the output register
// can take it, bounded by the single read and write port of the frame memory.
// After reset the frame reads as all zero until the first frame is written; no clearing pass.
// A stalled output register pauses the sweep; the next sample is taken once the last
// LED of the frame sits in the output register.
module led_strip_level_visualizer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lslv_amp_if.sink                         amp_in,
  lslv_led_if.source                       led_out,
  input  logic                             cfg_we_i,
  input  logic [lslv_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lslv_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  lslv_pkg::dp_cmd_t cmd;
  lslv_pkg::dp_sts_t sts;

  lslv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (amp_in.valid),
    .in_ready_o (amp_in.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lslv_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .amplitude_i    (amp_in.amplitude),
    .out_ready_i    (led_out.ready),
    .out_valid_o    (led_out.valid),
    .led_position_o (led_out.led_position),
    .led_color_o    (led_out.led_color),
    .frame_last_o   (led_out.frame_last),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  // a sample transaction starts a frame, so no second sample right after
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    amp_in.valid && amp_in.ready |=> !amp_in.ready)
    else $error("input ready right after a sample transaction");

  // while taking samples, only the final LED of a frame may still wait
  a_idle_only_at_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    amp_in.ready && led_out.valid |-> led_out.frame_last)
    else $error("input ready while a frame is still being sent");

  // within a frame the next LED follows at once with the next position
  a_sweep_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    led_out.valid && led_out.ready && !led_out.frame_last |=>
      led_out.valid &&
      (led_out.led_position == $past(led_out.led_position) + lslv_pkg::POS_W'(1)))
    else $error("frame sweep did not advance by one LED");

endmodule
